// ===== hw/rtl/biquad_pkg.sv =====
// Shared types, constants and saturation helpers for the biquad filter section.
// Depends on nothing; the other RTL files use scoped names, the bench imports it.

package biquad_pkg;

  // Number formats
  localparam int SAMPLE_BITS    = 24;
  localparam int COEF_FRAC_BITS = 28;
  localparam int COEF_BITS      = 32;
  localparam int STATE_BITS     = SAMPLE_BITS + 16;
  localparam int PROD_BITS      = COEF_BITS + SAMPLE_BITS;
  localparam int SCALED_BITS    = PROD_BITS - COEF_FRAC_BITS;
  localparam int ACC_BITS       = ((STATE_BITS > SCALED_BITS) ? STATE_BITS : SCALED_BITS) + 2;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = COEF_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [STATE_BITS-1:0]  state_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SCALED_BITS-1:0] scaled_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // Coefficient reset values
  localparam coef_t COEF_ONE  = coef_t'(longint'(1) <<< COEF_FRAC_BITS);
  localparam coef_t COEF_ZERO = '0;

  // Rounding offset added to every product before the scale-down shift
  localparam prod_t PROD_ROUND = prod_t'(longint'(1) <<< (COEF_FRAC_BITS - 1));

  // Saturation limits at accumulator width
  localparam longint SAMPLE_MAX_L = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint STATE_MAX_L  = (longint'(1) <<< (STATE_BITS - 1)) - 1;
  localparam acc_t ACC_SAMPLE_MAX = acc_t'(SAMPLE_MAX_L);
  localparam acc_t ACC_SAMPLE_MIN = acc_t'(-SAMPLE_MAX_L - 1);
  localparam acc_t ACC_STATE_MAX  = acc_t'(STATE_MAX_L);
  localparam acc_t ACC_STATE_MIN  = acc_t'(-STATE_MAX_L - 1);

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_B0,
    ST_Y,
    ST_MUL_A1,
    ST_MUL_B2,
    ST_MUL_A2,
    ST_DONE
  } ctrl_state_t;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_B0_X,
    MUL_B1_X,
    MUL_A1_Y,
    MUL_B2_X,
    MUL_A2_Y
  } mul_sel_t;

  // Accumulator operations
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_Y,
    ACC_N1_START,
    ACC_N1_SUB,
    ACC_N2_START
  } acc_op_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     load;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     commit;
  } dp_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

  // Clamp an accumulator value to the sample range
  function automatic sample_t sat_sample(input acc_t v);
    sample_t r;
    if (v > ACC_SAMPLE_MAX) begin
      r = sample_t'(ACC_SAMPLE_MAX);
    end else if (v < ACC_SAMPLE_MIN) begin
      r = sample_t'(ACC_SAMPLE_MIN);
    end else begin
      r = sample_t'(v);
    end
    return r;
  endfunction

  // Flag an accumulator value outside the sample range
  function automatic logic sample_over(input acc_t v);
    return (v > ACC_SAMPLE_MAX) || (v < ACC_SAMPLE_MIN);
  endfunction

  // Clamp an accumulator value to the state word range
  function automatic state_t sat_state(input acc_t v);
    state_t r;
    if (v > ACC_STATE_MAX) begin
      r = state_t'(ACC_STATE_MAX);
    end else if (v < ACC_STATE_MIN) begin
      r = state_t'(ACC_STATE_MIN);
    end else begin
      r = state_t'(v);
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/biquad_if.sv =====
// Valid/ready channel interfaces for input samples and filtered results.
// Depends on biquad_pkg for the payload types.

interface biquad_sample_if;
  logic                 valid;
  logic                 ready;
  biquad_pkg::sample_t  sample_in;
  logic                 block_end;

  modport source (output valid, output sample_in, output block_end, input ready);
  modport sink   (input valid, input sample_in, input block_end, output ready);
endinterface

interface biquad_result_if;
  logic                 valid;
  logic                 ready;
  biquad_pkg::sample_t  sample_out;
  logic                 block_end_out;
  logic                 clipped;

  modport source (output valid, output sample_out, output block_end_out, output clipped,
                  input ready);
  modport sink   (input valid, input sample_out, input block_end_out, input clipped,
                  output ready);
endinterface

// ===== hw/rtl/biquad_ctrl.sv =====
// Sequencer for the biquad section: steps the shared multiplier through the
// five products of one sample. Depends on biquad_pkg.

module biquad_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid,
  output logic                 ready,
  input  biquad_pkg::dp_stat_t stat,
  output biquad_pkg::dp_cmd_t  cmd
);

  biquad_pkg::ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= biquad_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    ready       = 1'b0;
    cmd.load    = 1'b0;
    cmd.mul_en  = 1'b0;
    cmd.mul_sel = biquad_pkg::MUL_B0_X;
    cmd.acc_op  = biquad_pkg::ACC_HOLD;
    cmd.commit  = 1'b0;
    unique case (state)
      biquad_pkg::ST_IDLE: begin
        ready = 1'b1;
        if (valid) begin
          cmd.load   = 1'b1;
          state_next = biquad_pkg::ST_MUL_B0;
        end
      end
      biquad_pkg::ST_MUL_B0: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biquad_pkg::MUL_B0_X;
        state_next  = biquad_pkg::ST_Y;
      end
      biquad_pkg::ST_Y: begin
        cmd.acc_op  = biquad_pkg::ACC_Y;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biquad_pkg::MUL_B1_X;
        state_next  = biquad_pkg::ST_MUL_A1;
      end
      biquad_pkg::ST_MUL_A1: begin
        cmd.acc_op  = biquad_pkg::ACC_N1_START;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biquad_pkg::MUL_A1_Y;
        state_next  = biquad_pkg::ST_MUL_B2;
      end
      biquad_pkg::ST_MUL_B2: begin
        cmd.acc_op  = biquad_pkg::ACC_N1_SUB;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biquad_pkg::MUL_B2_X;
        state_next  = biquad_pkg::ST_MUL_A2;
      end
      biquad_pkg::ST_MUL_A2: begin
        cmd.acc_op  = biquad_pkg::ACC_N2_START;
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = biquad_pkg::MUL_A2_Y;
        state_next  = biquad_pkg::ST_DONE;
      end
      biquad_pkg::ST_DONE: begin
        // Hold until the output register is free
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = biquad_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = biquad_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/biquad_dp.sv =====
// Datapath for the biquad section: coefficient registers, one shared multiplier,
// accumulators, delay state and the output register. Depends on biquad_pkg.

module biquad_dp (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       cfg_we,
  input  logic [biquad_pkg::CFG_INDEX_BITS-1:0]      cfg_index,
  input  logic [biquad_pkg::CFG_DATA_BITS-1:0]       cfg_data,
  input  biquad_pkg::sample_t                        sample_in,
  input  logic                                       block_end,
  input  biquad_pkg::dp_cmd_t                        cmd,
  output biquad_pkg::dp_stat_t                       stat,
  input  logic                                       res_ready,
  output logic                                       res_valid,
  output biquad_pkg::sample_t                        sample_out,
  output logic                                       block_end_out,
  output logic                                       clipped
);

  biquad_pkg::coef_t   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  biquad_pkg::sample_t x;
  logic                mark;
  biquad_pkg::prod_t   prod;
  biquad_pkg::sample_t y;
  logic                clip;
  biquad_pkg::acc_t    n1, n2;
  biquad_pkg::state_t  delay_one, delay_two;

  biquad_pkg::coef_t   mul_coef;
  biquad_pkg::sample_t mul_val;
  biquad_pkg::acc_t    scaled;
  biquad_pkg::acc_t    y_sum;

  // Coefficient registers; writes to unused indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= biquad_pkg::COEF_ONE;
      coef_b1 <= biquad_pkg::COEF_ZERO;
      coef_b2 <= biquad_pkg::COEF_ZERO;
      coef_a1 <= biquad_pkg::COEF_ZERO;
      coef_a2 <= biquad_pkg::COEF_ZERO;
    end else if (cfg_we) begin
      unique case (cfg_index)
        biquad_pkg::REG_B0: coef_b0 <= cfg_data;
        biquad_pkg::REG_B1: coef_b1 <= cfg_data;
        biquad_pkg::REG_B2: coef_b2 <= cfg_data;
        biquad_pkg::REG_A1: coef_a1 <= cfg_data;
        biquad_pkg::REG_A2: coef_a2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x    <= sample_in;
      mark <= block_end;
    end
  end

  // Select multiplier operands
  always_comb begin
    unique case (cmd.mul_sel)
      biquad_pkg::MUL_B0_X: begin mul_coef = coef_b0; mul_val = x; end
      biquad_pkg::MUL_B1_X: begin mul_coef = coef_b1; mul_val = x; end
      biquad_pkg::MUL_A1_Y: begin mul_coef = coef_a1; mul_val = y; end
      biquad_pkg::MUL_B2_X: begin mul_coef = coef_b2; mul_val = x; end
      biquad_pkg::MUL_A2_Y: begin mul_coef = coef_a2; mul_val = y; end
      default:              begin mul_coef = coef_b0; mul_val = x; end
    endcase
  end

  // Shared multiplier with the rounding offset folded in
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= biquad_pkg::prod_t'(mul_coef) * biquad_pkg::prod_t'(mul_val)
              + biquad_pkg::PROD_ROUND;
    end
  end

  // Scale the registered product back to sample scale
  assign scaled = biquad_pkg::acc_t'(biquad_pkg::scaled_t'(prod >>> biquad_pkg::COEF_FRAC_BITS));
  assign y_sum  = scaled + biquad_pkg::acc_t'(delay_one);

  // Accumulate output and new state words
  always_ff @(posedge clk) begin
    unique case (cmd.acc_op)
      biquad_pkg::ACC_Y: begin
        y    <= biquad_pkg::sat_sample(y_sum);
        clip <= biquad_pkg::sample_over(y_sum);
      end
      biquad_pkg::ACC_N1_START: n1 <= scaled + biquad_pkg::acc_t'(delay_two);
      biquad_pkg::ACC_N1_SUB:   n1 <= n1 - scaled;
      biquad_pkg::ACC_N2_START: n2 <= scaled;
      default: ;
    endcase
  end

  // Update the delay state at the end of each sample
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_one <= '0;
      delay_two <= '0;
    end else if (cmd.commit) begin
      delay_one <= biquad_pkg::sat_state(n1);
      delay_two <= biquad_pkg::sat_state(n2 - scaled);
    end
  end

  // Output register: hold while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.commit) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      sample_out    <= y;
      block_end_out <= mark;
      clipped       <= clip;
    end
  end

  assign stat.out_busy = res_valid && !res_ready;

endmodule

// ===== hw/rtl/biquad_iir_filter_section_top.sv =====
// Biquad IIR section (transposed direct form II), top level.
// Depends on biquad_pkg, biquad_if, biquad_ctrl and biquad_dp.
//
// Usage:
//   sample_ch carries one signed Q1.23 sample and a block-end mark per
//   transaction; result_ch returns one filtered, saturated sample with the
//   copied mark and a clip flag. Coefficients (Q4.28) are written through
//   cfg_we / cfg_index / cfg_data while the block is idle: 0 b0, 1 b1, 2 b2,
//   3 a1, 4 a2; other indexes are ignored.
//   Pacing: a new sample is accepted only once the previous one has been
//   committed, since the single multiplier forms the five products of a
//   sample in turn.
//   Reset (rst, synchronous): coefficients return to b0 = 1.0 and the others
//   to zero, both delay words clear and the output channel empties.
//   A stalled receiver: the result stays in the output register; the next
//   sample is still accepted and computed, then waits before its state update
//   until the output register is free.

module biquad_iir_filter_section_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [biquad_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [biquad_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  biquad_sample_if.sink                         sample_ch,
  biquad_result_if.source                       result_ch
);

  biquad_pkg::dp_cmd_t  cmd;
  biquad_pkg::dp_stat_t stat;

  // Sequencer
  biquad_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .valid (sample_ch.valid),
    .ready (sample_ch.ready),
    .stat  (stat),
    .cmd   (cmd)
  );

  // Arithmetic and state
  biquad_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_in     (sample_ch.sample_in),
    .block_end     (sample_ch.block_end),
    .cmd           (cmd),
    .stat          (stat),
    .res_ready     (result_ch.ready),
    .res_valid     (result_ch.valid),
    .sample_out    (result_ch.sample_out),
    .block_end_out (result_ch.block_end_out),
    .clipped       (result_ch.clipped)
  );

endmodule

// ===== bench/tb_biquad_iir_filter_section_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the biquad IIR section: directed and random samples over several
// coefficient sets, checked against a cycle-free filter prediction. Needs biquad_pkg, biquad_if.

module tb_biquad_iir_filter_section_top;
  import biquad_pkg::*;

  localparam int     SETTLE_CYCLES   = 8;
  localparam int     MAX_IDLE        = 16;
  localparam int     RANDOM_SETS     = 8;
  localparam int     SET_ITEMS       = 130;
  localparam longint LIMIT_NS        = 5_000_000;
  localparam int     REG_SPARE_FIRST = 5;

  localparam sample_t SMP_MAX   = sample_t'(SAMPLE_MAX_L);
  localparam sample_t SMP_MIN   = sample_t'(-SAMPLE_MAX_L - 1);
  localparam coef_t   COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam coef_t   COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam coef_t   COEF_HALF = COEF_ONE >>> 1;

  typedef struct {
    sample_t smp;
    logic    blk_end;
  } smp_item_t;

  typedef struct {
    sample_t smp;
    logic    blk_end;
    logic    clip;
  } filt_res_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  biquad_sample_if sample_ch ();
  biquad_result_if result_ch ();

  biquad_iir_filter_section_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample_ch (sample_ch),
    .result_ch (result_ch)
  );

  // Samples waiting for the driver, filtered samples waiting for the output channel
  smp_item_t pending_q[$];
  filt_res_t expected_q[$];

  // Predicted coefficient registers and delay words
  coef_t  k_b0, k_b1, k_b2, k_a1, k_a2;
  state_t z1, z2;

  int n_offered, n_taken, n_results, n_seen;
  int n_errors, n_clipped, n_marks, n_writes;
  int tx_wait, rx_wait;
  bit tx_busy;
  bit tx_idle_en, rx_idle_en;

  // Coefficient times value, rounded half up back to sample scale
  function automatic longint coef_times(input coef_t c, input longint v);
    longint p;
    p = longint'(c) * v + (longint'(1) <<< (COEF_FRAC_BITS - 1));
    return p >>> COEF_FRAC_BITS;
  endfunction

  function automatic longint clamp_to(input longint v, input int bits, output bit hit);
    longint hi, lo, r;
    hi  = (longint'(1) <<< (bits - 1)) - 1;
    lo  = -hi - 1;
    hit = 1'b0;
    r   = v;
    if (v > hi) begin
      hit = 1'b1;
      r   = hi;
    end else if (v < lo) begin
      hit = 1'b1;
      r   = lo;
    end
    return r;
  endfunction

  // Transposed direct form II step: output from the first delay word, then update both
  function automatic filt_res_t filter_step(input smp_item_t it);
    filt_res_t r;
    longint    acc, y, n1, n2;
    bit        hit, state_hit;
    acc = coef_times(k_b0, it.smp) + z1;
    y   = clamp_to(acc, SAMPLE_BITS, hit);
    // feedback uses the saturated output
    n1  = coef_times(k_b1, it.smp) - coef_times(k_a1, y) + z2;
    n2  = coef_times(k_b2, it.smp) - coef_times(k_a2, y);
    z1  = state_t'(clamp_to(n1, STATE_BITS, state_hit));
    z2  = state_t'(clamp_to(n2, STATE_BITS, state_hit));
    r.smp     = sample_t'(y);
    r.blk_end = it.blk_end;
    r.clip    = hit;
    return r;
  endfunction

  function automatic sample_t draw_sample();
    sample_t v;
    case ($urandom_range(0, 7))
      0:       v = SMP_MAX;
      1:       v = SMP_MIN;
      2, 3:    v = sample_t'(int'($urandom_range(0, 2047)) - 1024);
      default: v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  // Style 0: gentle filters, 1: any 32-bit value, 2: extremes, unity and zero mixed in
  function automatic coef_t draw_coef(input int style);
    coef_t c;
    if (style == 0) begin
      c = coef_t'(int'($urandom_range(0, 1 << 29)) - (1 << 28));
    end else if (style == 1) begin
      c = coef_t'($urandom);
    end else begin
      case ($urandom_range(0, 4))
        0:       c = COEF_MAX;
        1:       c = COEF_MIN;
        2:       c = COEF_ZERO;
        3:       c = COEF_ONE;
        default: c = coef_t'($urandom);
      endcase
    end
    return c;
  endfunction

  function automatic void queue_item(input sample_t s, input logic b);
    smp_item_t it;
    it.smp     = s;
    it.blk_end = b;
    pending_q.push_back(it);
  endfunction

  // Write one register while the block is idle and mirror it in the prediction
  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx, input coef_t val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_B0:  k_b0 = val;
      REG_B1:  k_b1 = val;
      REG_B2:  k_b2 = val;
      REG_A1:  k_a1 = val;
      REG_A2:  k_a2 = val;
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic write_set(input coef_t b0, input coef_t b1, input coef_t b2,
                           input coef_t a1, input coef_t a2);
    write_reg(REG_B0, b0);
    write_reg(REG_B1, b1);
    write_reg(REG_B2, b2);
    write_reg(REG_A1, a1);
    write_reg(REG_A2, a2);
  endtask

  // Hold until every sample is taken and every result is back, then let the pipe drain
  task automatic wait_idle();
    while (pending_q.size() != 0 || n_taken != n_offered || expected_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Input driver: present queued samples at the falling edge, randomly gapped if tx_idle_en
  always @(negedge clk) begin
    smp_item_t nxt;
    if (rst) begin
      sample_ch.valid <= 1'b0;
      tx_busy = 1'b0;
      tx_wait = 0;
    end else begin
      if (tx_busy && n_taken == n_offered) tx_busy = 1'b0;
      if (!tx_busy) begin
        if (tx_wait > 0) begin
          tx_wait--;
        end else if (pending_q.size() > 0) begin
          nxt = pending_q.pop_front();
          sample_ch.valid     <= 1'b1;
          sample_ch.sample_in <= nxt.smp;
          sample_ch.block_end <= nxt.blk_end;
          tx_busy = 1'b1;
          n_offered++;
          tx_wait = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        end
      end
      if (!tx_busy) sample_ch.valid <= 1'b0;
    end
  end

  // Input monitor: predict the result of every accepted transaction
  always @(posedge clk) begin
    smp_item_t taken;
    if (!rst && sample_ch.valid && sample_ch.ready) begin
      taken.smp     = sample_ch.sample_in;
      taken.blk_end = sample_ch.block_end;
      expected_q.push_back(filter_step(taken));
      n_taken++;
    end
  end

  // Output side: if rx_idle_en, stall a random number of cycles after each result
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (n_seen != n_results) begin
        n_seen  = n_results;
        rx_wait = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // Output monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    filt_res_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        n_errors++;
        $display("%0t: result with none expected: sample %0d mark %0b clip %0b", $time,
                 result_ch.sample_out, result_ch.block_end_out, result_ch.clipped);
      end else begin
        want = expected_q.pop_front();
        if (want.clip) n_clipped++;
        if (want.blk_end) n_marks++;
        if (result_ch.sample_out !== want.smp || result_ch.block_end_out !== want.blk_end ||
            result_ch.clipped !== want.clip) begin
          n_errors++;
          $display("%0t: expected sample %0d mark %0b clip %0b, got sample %0d mark %0b clip %0b",
                   $time, want.smp, want.blk_end, want.clip, result_ch.sample_out,
                   result_ch.block_end_out, result_ch.clipped);
        end
      end
    end
  end

  // Stimulus
  initial begin
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    sample_ch.valid     = 1'b0;
    sample_ch.sample_in = '0;
    sample_ch.block_end = 1'b0;
    result_ch.ready     = 1'b0;
    k_b0 = COEF_ONE;
    k_b1 = COEF_ZERO;
    k_b2 = COEF_ZERO;
    k_a1 = COEF_ZERO;
    k_a2 = COEF_ZERO;
    z1   = '0;
    z2   = '0;
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rst = 1'b1;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // reset coefficients pass samples straight through
    queue_item(SMP_MAX, 1'b0);
    queue_item(SMP_MIN, 1'b1);
    queue_item(sample_t'(0), 1'b0);
    queue_item(sample_t'(-1), 1'b0);
    queue_item(sample_t'(1), 1'b1);
    queue_item(sample_t'(24'h5a5a5a), 1'b0);
    wait_idle();

    // writes to unused indexes must leave the coefficients alone
    for (int i = REG_SPARE_FIRST; i < (1 << CFG_INDEX_BITS); i++) begin
      write_reg(CFG_INDEX_BITS'(i), coef_t'($urandom));
    end
    queue_item(SMP_MAX, 1'b1);
    queue_item(SMP_MIN, 1'b0);
    wait_idle();

    // extreme coefficients: saturation in both directions, feedback from the clamped output
    write_set(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    queue_item(SMP_MAX, 1'b0);
    queue_item(SMP_MIN, 1'b0);
    queue_item(sample_t'(0), 1'b1);
    queue_item(sample_t'(-1), 1'b0);
    queue_item(sample_t'(1), 1'b0);
    queue_item(SMP_MIN, 1'b0);
    queue_item(SMP_MAX, 1'b1);
    wait_idle();
    write_set(COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN);
    queue_item(SMP_MIN, 1'b0);
    queue_item(SMP_MAX, 1'b0);
    queue_item(sample_t'(0), 1'b0);
    queue_item(sample_t'(0), 1'b1);
    wait_idle();

    // half gain: products land exactly on the rounding midpoint
    write_set(COEF_HALF, COEF_ZERO, COEF_ZERO, COEF_ZERO, COEF_ZERO);
    queue_item(sample_t'(1), 1'b0);
    queue_item(sample_t'(-1), 1'b0);
    queue_item(sample_t'(3), 1'b0);
    queue_item(sample_t'(-3), 1'b1);
    wait_idle();

    // random coefficient sets, each run to completion before the next is loaded
    for (int s = 0; s < RANDOM_SETS; s++) begin
      tx_idle_en = s[0];
      rx_idle_en = s[1];
      write_set(draw_coef(s % 3), draw_coef(s % 3), draw_coef(s % 3),
                draw_coef(s % 3), draw_coef(s % 3));
      repeat (SET_ITEMS) queue_item(draw_sample(), $urandom_range(0, 7) == 0);
      wait_idle();
    end

    $display("Run covered %0d samples with %0d register writes over %0d random sets;",
             n_results, n_writes, RANDOM_SETS);
    $display("%0d outputs saturated and %0d block ends passed through.", n_clipped, n_marks);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/biquad_pkg.sv
hw/rtl/biquad_if.sv
hw/rtl/biquad_ctrl.sv
hw/rtl/biquad_dp.sv
hw/rtl/biquad_iir_filter_section_top.sv
bench/tb_biquad_iir_filter_section_top.sv
